/* rtl/core/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared widths, codes and control structs for the monochrome line store.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int COLUMNS_DEF = 400;
  localparam int ROWS_DEF    = 240;
  localparam int SPAN_DEF    = 24;

  localparam int OP_W    = 3;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int VALUE_W = 24;
  localparam int ROP_W   = 2;
  localparam int KIND_W  = 2;
  localparam int WIDX_W  = 3;
  localparam int DATA_W  = 64;

  localparam logic [OP_W-1:0] OP_BLIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEND  = 3'd4;

  localparam logic [ROP_W-1:0] ROP_OR     = 2'd0;
  localparam logic [ROP_W-1:0] ROP_XOR    = 2'd1;
  localparam logic [ROP_W-1:0] ROP_ANDNOT = 2'd2;
  localparam logic [ROP_W-1:0] ROP_BAD    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic           set_all;
    logic           mark;
    logic           clear;
    logic           scan;
    logic [Y_W-1:0] row;
  } dirty_cmd_t;

  typedef struct packed {
    logic           done;
    logic           found;
    logic [Y_W-1:0] row;
  } dirty_stat_t;

endpackage

/* rtl/core/mfb_store.sv */
// ----------------------------------------------------------------------------
// mfb_store
// Pixel word memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfb_store #(
  parameter int DEPTH = 1680,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [mfb_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [mfb_pkg::DATA_W-1:0] rd_data
);
  import mfb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/mfb_dirty.sv */
// ----------------------------------------------------------------------------
// mfb_dirty
// Per-row dirty flags with a group-at-a-time search for the lowest dirty row.
// ----------------------------------------------------------------------------
module mfb_dirty #(
  parameter int SCREEN_ROWS = 240
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mfb_pkg::dirty_cmd_t  cmd,
  output mfb_pkg::dirty_stat_t stat
);
  import mfb_pkg::*;

  localparam int GRP     = 16;
  localparam int NGROUPS = (SCREEN_ROWS + GRP - 1) / GRP;
  localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int DIRTY_W = NGROUPS * GRP;
  localparam int IDX_W   = $clog2(DIRTY_W);
  localparam logic [DIRTY_W-1:0] ROW_MASK = {DIRTY_W{1'b1}} >> (DIRTY_W - SCREEN_ROWS);

  logic [DIRTY_W-1:0] flags;
  logic               scanning;
  logic [GW-1:0]      grp_idx;
  logic [GRP-1:0]     grp_bits;
  logic [3:0]         low_bit;
  logic               stat_done;
  logic               stat_found;
  logic [Y_W-1:0]     stat_row;

  assign grp_bits = GRP'(flags >> {grp_idx, 4'b0});

  always_comb begin
    low_bit = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        low_bit = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= ROW_MASK;
      scanning   <= 1'b0;
      grp_idx    <= '0;
      stat_done  <= 1'b0;
      stat_found <= 1'b0;
    end else begin
      stat_done <= 1'b0;
      if (cmd.set_all) begin
        flags <= flags | ROW_MASK;
      end
      if (cmd.mark) begin
        flags[cmd.row[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.clear) begin
        flags[cmd.row[IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.scan) begin
        scanning <= 1'b1;
        grp_idx  <= '0;
      end else if (scanning) begin
        if (grp_bits != '0) begin
          scanning   <= 1'b0;
          stat_done  <= 1'b1;
          stat_found <= 1'b1;
          stat_row   <= Y_W'({grp_idx, low_bit});
        end else if (grp_idx == GW'(NGROUPS - 1)) begin
          scanning   <= 1'b0;
          stat_done  <= 1'b1;
          stat_found <= 1'b0;
        end else begin
          grp_idx <= grp_idx + 1'b1;
        end
      end
    end
  end

  assign stat.done  = stat_done;
  assign stat.found = stat_found;
  assign stat.row   = stat_row;

endmodule

/* rtl/core/mono_framebuffer_blit_dirty_rows_core.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_blit_dirty_rows_core
// One-bit-per-pixel line store with blit, rectangle fill and dirty-row send.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Pixels live in a
// memory of 64-bit words, ROW_WORDS words per row, and every blit or fill
// runs as a read-modify-write through its single read and write port, each
// word read in S_RD, written in S_WR: one or two words of a row for a blit,
// each covered word of every row for a fill. Clear-all and reset both sweep
// the memory one word a cycle (SCREEN_ROWS*ROW_WORDS words, 1680 by default)
// while busy is high. Send searches the dirty flags 16 rows a cycle, then
// streams one word per cycle. Every result appears for one cycle on strobe
// and must be taken then: the block cannot be stalled on its result side.
module mono_framebuffer_blit_dirty_rows_core #(
  parameter int SCREEN_COLUMNS = mfb_pkg::COLUMNS_DEF,
  parameter int SCREEN_ROWS    = mfb_pkg::ROWS_DEF,
  parameter int SPAN_MAX       = mfb_pkg::SPAN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mfb_pkg::OP_W-1:0]    op,
  input  logic [mfb_pkg::X_W-1:0]     x,
  input  logic [mfb_pkg::Y_W-1:0]     y,
  input  logic [mfb_pkg::X_W-1:0]     width,
  input  logic [mfb_pkg::Y_W-1:0]     height,
  input  logic [mfb_pkg::VALUE_W-1:0] value,
  input  logic [mfb_pkg::ROP_W-1:0]   rop,
  input  logic                        fill_set,
  output logic                        strobe,
  output logic [mfb_pkg::KIND_W-1:0]  kind,
  output logic [mfb_pkg::Y_W-1:0]     line_id,
  output logic [mfb_pkg::WIDX_W-1:0]  word_index,
  output logic [mfb_pkg::DATA_W-1:0]  data,
  output logic                        last
);
  import mfb_pkg::*;

  localparam int ROW_BYTES  = (SCREEN_COLUMNS + 7) / 8;
  localparam int ROW_WORDS  = (ROW_BYTES + 7) / 8;
  localparam int DEPTH      = SCREEN_ROWS * ROW_WORDS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int LAST_BYTES = ROW_BYTES - 8 * (ROW_WORDS - 1);
  localparam int WIDE_W     = DATA_W + VALUE_W;
  localparam logic [DATA_W-1:0] LAST_MASK = {DATA_W{1'b1}} >> (DATA_W - 8 * LAST_BYTES);
  localparam logic [WIDX_W-1:0] LAST_K    = WIDX_W'(ROW_WORDS - 1);
  localparam logic [X_W:0]      COLS      = (X_W + 1)'(SCREEN_COLUMNS);
  localparam logic [Y_W:0]      ROWS      = (Y_W + 1)'(SCREEN_ROWS);
  localparam logic [X_W-1:0]    SPAN      = X_W'(SPAN_MAX);
  localparam logic [Y_W-1:0]    LINE_TOP  = Y_W'(SCREEN_ROWS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  localparam logic [1:0] SRC_VAL  = 2'd0;
  localparam logic [1:0] SRC_MASK = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  function automatic logic [DATA_W-1:0] ones_from(input logic [X_W-1:0] n,
                                                  input logic [X_W:0] base);
    logic [X_W:0] rel;
    rel = {1'b0, n} - base;
    if ({1'b0, n} <= base) begin
      return '1;
    end else if (rel >= (X_W + 1)'(DATA_W)) begin
      return '0;
    end else begin
      return {DATA_W{1'b1}} << rel[5:0];
    end
  endfunction

  logic [2:0]          state;
  logic [Y_W-1:0]      row_q;
  logic [Y_W-1:0]      row_last;
  logic [WIDX_W-1:0]   k_q;
  logic [WIDX_W-1:0]   k_first;
  logic [WIDX_W-1:0]   k_last;
  logic [X_W-1:0]      lo_q;
  logic [X_W-1:0]      hi_q;
  logic [WIDE_W-1:0]   wide_q;
  logic [ROP_W-1:0]    rop_q;
  logic [1:0]          src_q;
  logic [ADDR_W-1:0]   clr_addr;
  logic                clr_reply;
  logic                pend_valid;
  logic [WIDX_W-1:0]   pend_k;

  logic [X_W:0]        x_end;
  logic [Y_W:0]        y_end;
  logic                blit_ok;
  logic                fill_ok;
  logic                fill_empty;
  logic [X_W-1:0]      lo_in;
  logic [X_W-1:0]      hi_in;
  logic [X_W-1:0]      hi_m1;
  logic [VALUE_W:0]    span_mask;
  logic [VALUE_W-1:0]  val_m;
  logic [WIDE_W-1:0]   wide_in;
  logic [1:0]          src_in;

  logic [X_W:0]        base;
  logic [DATA_W-1:0]   mask_w;
  logic [DATA_W-1:0]   src_w;
  logic [DATA_W-1:0]   new_w;
  logic [ADDR_W-1:0]   word_addr;
  logic                clr_end;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [DATA_W-1:0]   rd_data;

  dirty_cmd_t          dcmd;
  dirty_stat_t         dstat;

  logic                res_load;
  logic [KIND_W-1:0]   res_kind;
  logic [Y_W-1:0]      res_line;
  logic [WIDX_W-1:0]   res_word;
  logic [DATA_W-1:0]   res_data;
  logic                res_last;

  assign busy = (state != S_IDLE);

  always_comb begin
    x_end      = {1'b0, x} + {1'b0, width};
    y_end      = {1'b0, y} + {1'b0, height};
    blit_ok    = (width != '0) && (width <= SPAN) && ({1'b0, x} < COLS) &&
                 (x_end <= COLS) && ({1'b0, y} < ROWS) && (rop != ROP_BAD);
    fill_ok    = (x_end <= COLS) && (y_end <= ROWS);
    fill_empty = (width == '0) || (height == '0);
    lo_in      = X_W'(COLS - x_end);
    hi_in      = X_W'(COLS - {1'b0, x});
    hi_m1      = hi_in - 1'b1;
    span_mask  = ((VALUE_W + 1)'(1) << width[4:0]) - 1'b1;
    val_m      = value & span_mask[VALUE_W-1:0];
    wide_in    = WIDE_W'(val_m) << lo_in[5:0];
    if (fill_set && rop != ROP_XOR) begin
      src_in = (rop == ROP_ANDNOT) ? SRC_MASK : SRC_ZERO;
    end else begin
      src_in = SRC_VAL;
    end
  end

  always_comb begin
    base   = {1'b0, k_q, 6'b0};
    mask_w = ones_from(lo_q, base) & ~ones_from(hi_q, base);
    unique case (src_q)
      SRC_VAL:  src_w = (k_q == k_first) ? wide_q[DATA_W-1:0]
                                         : DATA_W'(wide_q[WIDE_W-1:DATA_W]);
      SRC_MASK: src_w = mask_w;
      default:  src_w = '0;
    endcase
    unique case (rop_q)
      ROP_OR:  new_w = rd_data | src_w;
      ROP_XOR: new_w = rd_data ^ src_w;
      default: new_w = rd_data & ~src_w;
    endcase
    word_addr = ADDR_W'(int'(row_q) * ROW_WORDS + int'(k_q));
    clr_end   = (clr_addr == ADDR_W'(DEPTH - 1));
  end

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_WR);
    mem_waddr = (state == S_CLEAR) ? clr_addr : word_addr;
    mem_wdata = (state == S_CLEAR) ? '1 : new_w;
    mem_re    = (state == S_RD) || (state == S_SEND);
  end

  mfb_store #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(word_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    dcmd.set_all = (state == S_IDLE) && start && (op == OP_CLEAR || op == OP_MARK);
    dcmd.mark    = (state == S_WR) && (k_q == k_last);
    dcmd.clear   = (state == S_SCAN) && dstat.done && dstat.found;
    dcmd.scan    = (state == S_IDLE) && start && (op == OP_SEND);
    dcmd.row     = (state == S_SCAN) ? dstat.row : row_q;
  end

  mfb_dirty #(
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_dirty (
    .clk (clk),
    .rst (rst),
    .cmd (dcmd),
    .stat(dstat)
  );

  always_comb begin
    res_load = 1'b0;
    res_kind = KIND_DONE;
    res_line = '0;
    res_word = '0;
    res_data = '0;
    res_last = 1'b1;
    if (pend_valid) begin
      res_load = 1'b1;
      res_kind = KIND_ROW;
      res_line = LINE_TOP - row_q;
      res_word = pend_k;
      res_data = rd_data & ((pend_k == LAST_K) ? LAST_MASK : {DATA_W{1'b1}});
      res_last = (pend_k == LAST_K);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            priority case (op)
              OP_BLIT: begin
                res_load = !blit_ok;
                res_kind = KIND_IGNORED;
              end
              OP_FILL: begin
                res_load = !fill_ok || fill_empty;
                res_kind = fill_ok ? KIND_DONE : KIND_IGNORED;
              end
              OP_MARK: res_load = 1'b1;
              OP_CLEAR, OP_SEND: res_load = 1'b0;
              default: begin
                res_load = 1'b1;
                res_kind = KIND_IGNORED;
              end
            endcase
          end
        end
        S_CLEAR: res_load = clr_end && clr_reply;
        S_WR:    res_load = (k_q == k_last) && (row_q == row_last);
        S_SCAN: begin
          res_load = dstat.done && !dstat.found;
          res_kind = KIND_NONE;
        end
        default: res_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe     <= res_load;
      pend_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            priority case (op)
              OP_BLIT: begin
                if (blit_ok) begin
                  row_q    <= y;
                  row_last <= y;
                  lo_q     <= lo_in;
                  hi_q     <= hi_in;
                  k_q      <= lo_in[X_W-1:6];
                  k_first  <= lo_in[X_W-1:6];
                  k_last   <= hi_m1[X_W-1:6];
                  wide_q   <= wide_in;
                  rop_q    <= rop;
                  src_q    <= src_in;
                  state    <= S_RD;
                end
              end
              OP_FILL: begin
                if (fill_ok && !fill_empty) begin
                  row_q    <= y;
                  row_last <= Y_W'(y_end - 1'b1);
                  lo_q     <= lo_in;
                  hi_q     <= hi_in;
                  k_q      <= lo_in[X_W-1:6];
                  k_first  <= lo_in[X_W-1:6];
                  k_last   <= hi_m1[X_W-1:6];
                  rop_q    <= (value != '0) ? ROP_OR : ROP_ANDNOT;
                  src_q    <= SRC_MASK;
                  state    <= S_RD;
                end
              end
              OP_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              OP_SEND: state <= S_SCAN;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_end) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (k_q != k_last) begin
            k_q   <= k_q + 1'b1;
            state <= S_RD;
          end else if (row_q != row_last) begin
            row_q <= row_q + 1'b1;
            k_q   <= k_first;
            state <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (dstat.done) begin
            if (dstat.found) begin
              row_q <= dstat.row;
              k_q   <= '0;
              state <= S_SEND;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SEND: begin
          pend_valid <= 1'b1;
          pend_k     <= k_q;
          if (k_q == LAST_K) begin
            state <= S_DRAIN;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_DRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind       <= res_kind;
      line_id    <= res_line;
      word_index <= res_word;
      data       <= res_data;
      last       <= res_last;
    end
  end

endmodule

/* tb/mfb_checker.sv */
// ----------------------------------------------------------------------------
// mfb_checker
// Watches the command and result channels of the monochrome line store,
// keeps a shadow copy of the pixel rows and dirty flags, predicts the
// results of every accepted transaction and compares them in order.
// ----------------------------------------------------------------------------
module mfb_checker #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEF,
  parameter int ROWS    = mfb_pkg::ROWS_DEF,
  parameter int SPAN    = mfb_pkg::SPAN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [mfb_pkg::OP_W-1:0]    op,
  input  logic [mfb_pkg::X_W-1:0]     x,
  input  logic [mfb_pkg::Y_W-1:0]     y,
  input  logic [mfb_pkg::X_W-1:0]     width,
  input  logic [mfb_pkg::Y_W-1:0]     height,
  input  logic [mfb_pkg::VALUE_W-1:0] value,
  input  logic [mfb_pkg::ROP_W-1:0]   rop,
  input  logic                        fill_set,
  input  logic                        strobe,
  input  logic [mfb_pkg::KIND_W-1:0]  kind,
  input  logic [mfb_pkg::Y_W-1:0]     line_id,
  input  logic [mfb_pkg::WIDX_W-1:0]  word_index,
  input  logic [mfb_pkg::DATA_W-1:0]  data,
  input  logic                        last,
  output int                          pending,
  output int                          fail_count
);
  import mfb_pkg::*;

  localparam int ROW_BYTES = (COLUMNS + 7) / 8;
  localparam int ROW_WORDS = (ROW_BYTES + 7) / 8;
  localparam int IMG_W     = ROW_WORDS * DATA_W;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [Y_W-1:0]    line_id;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] data;
    logic              last;
  } row_result_t;

  bit [COLUMNS-1:0] shadow_rows [ROWS];
  bit               shadow_dirty [ROWS];
  row_result_t      expected_results [$];

  initial fail_count = 0;
  initial pending = 0;

  task automatic push_result(input logic [KIND_W-1:0] k, input int unsigned line,
                             input int unsigned widx, input logic [DATA_W-1:0] d,
                             input logic l);
    row_result_t e;
    e.kind       = k;
    e.line_id    = line[Y_W-1:0];
    e.word_index = widx[WIDX_W-1:0];
    e.data       = d;
    e.last       = l;
    expected_results.push_back(e);
  endtask

  task automatic reset_shadow();
    for (int r = 0; r < ROWS; r++) begin
      shadow_rows[r]  = '1;
      shadow_dirty[r] = 1'b1;
    end
  endtask

  task automatic predict_command(input logic [OP_W-1:0] c_op, input int unsigned c_x,
                                 input int unsigned c_y, input int unsigned c_w,
                                 input int unsigned c_h, input logic [VALUE_W-1:0] c_value,
                                 input logic [ROP_W-1:0] c_rop, input logic c_solid);
    int unsigned      endx;
    int unsigned      endy;
    int unsigned      xm;
    int               hit;
    bit [COLUMNS-1:0] mask;
    bit [COLUMNS-1:0] src;
    bit [IMG_W-1:0]   img;
    case (c_op)
      OP_BLIT: begin
        if (c_w < 1 || c_w > SPAN || c_x >= COLUMNS || c_x + c_w > COLUMNS ||
            c_y >= ROWS || c_rop == ROP_BAD) begin
          push_result(KIND_IGNORED, 0, 0, '0, 1'b1);
        end else begin
          xm   = COLUMNS - c_w - c_x;
          mask = {COLUMNS{1'b1}} >> (COLUMNS - c_w);
          if (c_solid && c_rop != ROP_XOR) begin
            src = (c_rop == ROP_ANDNOT) ? (mask << xm) : '0;
          end else begin
            src = (COLUMNS'(c_value) & mask) << xm;
          end
          case (c_rop)
            ROP_OR:  shadow_rows[c_y] = shadow_rows[c_y] | src;
            ROP_XOR: shadow_rows[c_y] = shadow_rows[c_y] ^ src;
            default: shadow_rows[c_y] = shadow_rows[c_y] & ~src;
          endcase
          shadow_dirty[c_y] = 1'b1;
          push_result(KIND_DONE, 0, 0, '0, 1'b1);
        end
      end
      OP_FILL: begin
        endx = c_x + c_w;
        endy = c_y + c_h;
        if (endx > COLUMNS || endy > ROWS) begin
          push_result(KIND_IGNORED, 0, 0, '0, 1'b1);
        end else begin
          // columns x..endx-1 land mirrored at store bits COLUMNS-endx..COLUMNS-1-x
          mask = ({COLUMNS{1'b1}} >> (COLUMNS - c_w)) << (COLUMNS - endx);
          if (c_w != 0) begin
            for (int unsigned r = c_y; r < endy; r++) begin
              if (c_value != '0) shadow_rows[r] = shadow_rows[r] | mask;
              else shadow_rows[r] = shadow_rows[r] & ~mask;
              shadow_dirty[r] = 1'b1;
            end
          end
          push_result(KIND_DONE, 0, 0, '0, 1'b1);
        end
      end
      OP_CLEAR: begin
        reset_shadow();
        push_result(KIND_DONE, 0, 0, '0, 1'b1);
      end
      OP_MARK: begin
        for (int r = 0; r < ROWS; r++) shadow_dirty[r] = 1'b1;
        push_result(KIND_DONE, 0, 0, '0, 1'b1);
      end
      OP_SEND: begin
        hit = -1;
        for (int r = ROWS - 1; r >= 0; r--) begin
          if (shadow_dirty[r]) hit = r;
        end
        if (hit < 0) begin
          push_result(KIND_NONE, 0, 0, '0, 1'b1);
        end else begin
          shadow_dirty[hit] = 1'b0;
          img = IMG_W'(shadow_rows[hit]);
          for (int k = 0; k < ROW_WORDS; k++) begin
            push_result(KIND_ROW, ROWS - 1 - hit, k, img[k*DATA_W +: DATA_W],
                        k == ROW_WORDS - 1);
          end
        end
      end
      default: push_result(KIND_IGNORED, 0, 0, '0, 1'b1);
    endcase
  endtask

  task automatic note_mismatch(input string what, input row_result_t want,
                               input row_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch (%s): expected kind=%0d line=%0d word=%0d data=%h last=%0b",
               what, want.kind, want.line_id, want.word_index, want.data, want.last);
      $display("               got      kind=%0d line=%0d word=%0d data=%h last=%0b",
               got.kind, got.line_id, got.word_index, got.data, got.last);
    end
  endtask

  always @(posedge clk) begin
    row_result_t want;
    row_result_t got;
    if (rst) begin
      reset_shadow();
      expected_results.delete();
    end else begin
      if (start && !busy) begin
        predict_command(op, x, y, width, height, value, rop, fill_set);
      end
      if (strobe) begin
        got.kind       = kind;
        got.line_id    = line_id;
        got.word_index = word_index;
        got.data       = data;
        got.last       = last;
        if (expected_results.size() == 0) begin
          want = '{default: '0};
          note_mismatch("no result expected", want, got);
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== got.kind || want.line_id !== got.line_id ||
              want.word_index !== got.word_index || want.data !== got.data ||
              want.last !== got.last) begin
            note_mismatch("field", want, got);
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives blit, fill, clear, mark, send and undefined-opcode transactions into
// the line store with random gaps; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import mfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [X_W-1:0]     width;
    logic [Y_W-1:0]     height;
    logic [VALUE_W-1:0] value;
    logic [ROP_W-1:0]   rop;
    logic               fill_set;
  } command_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    op = '0;
  logic [X_W-1:0]     x = '0;
  logic [Y_W-1:0]     y = '0;
  logic [X_W-1:0]     width = '0;
  logic [Y_W-1:0]     height = '0;
  logic [VALUE_W-1:0] value = '0;
  logic [ROP_W-1:0]   rop = '0;
  logic               fill_set = 1'b0;
  logic               strobe;
  logic [KIND_W-1:0]  kind;
  logic [Y_W-1:0]     line_id;
  logic [WIDX_W-1:0]  word_index;
  logic [DATA_W-1:0]  data;
  logic               last;
  int                 pending;
  int                 fail_count;
  int                 idle_cycles = 0;

  always #4 clk = ~clk;

  mono_framebuffer_blit_dirty_rows_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .x(x), .y(y), .width(width), .height(height), .value(value),
    .rop(rop), .fill_set(fill_set),
    .strobe(strobe), .kind(kind), .line_id(line_id), .word_index(word_index),
    .data(data), .last(last)
  );

  mfb_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .x(x), .y(y), .width(width), .height(height), .value(value),
    .rop(rop), .fill_set(fill_set),
    .strobe(strobe), .kind(kind), .line_id(line_id), .word_index(word_index),
    .data(data), .last(last),
    .pending(pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  function automatic command_t make_cmd(input logic [OP_W-1:0] c_op, input int unsigned c_x,
                                        input int unsigned c_y, input int unsigned c_w,
                                        input int unsigned c_h, input int unsigned c_v,
                                        input logic [ROP_W-1:0] c_rop, input logic c_fs);
    command_t c;
    c.op       = c_op;
    c.x        = c_x[X_W-1:0];
    c.y        = c_y[Y_W-1:0];
    c.width    = c_w[X_W-1:0];
    c.height   = c_h[Y_W-1:0];
    c.value    = c_v[VALUE_W-1:0];
    c.rop      = c_rop;
    c.fill_set = c_fs;
    return c;
  endfunction

  function automatic command_t raw_cmd(input logic [OP_W-1:0] c_op);
    return make_cmd(c_op, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 3), $urandom_range(0, 1));
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic command_t rand_cmd();
    command_t    c;
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int unsigned py;
    r = $urandom_range(0, 99);
    c = raw_cmd(OP_BLIT);
    if (r < 38) begin
      w = $urandom_range(1, SPAN_DEF);
      c = make_cmd(OP_BLIT, $urandom_range(0, COLUMNS_DEF - w), $urandom_range(0, ROWS_DEF - 1),
                   w, $urandom, $urandom, $urandom_range(0, 2), $urandom_range(0, 1));
    end else if (r < 46) begin
      c = raw_cmd(OP_BLIT);
    end else if (r < 58) begin
      w = $urandom_range(0, 60);
      h = $urandom_range(0, 4);
      c = make_cmd(OP_FILL, $urandom_range(0, COLUMNS_DEF - w), $urandom_range(0, ROWS_DEF - h),
                   w, h, ($urandom_range(0, 1) != 0) ? $urandom : 0,
                   $urandom_range(0, 3), $urandom_range(0, 1));
    end else if (r < 61) begin
      c = raw_cmd(OP_FILL);
    end else if (r < 62) begin
      py = $urandom_range(0, 100);
      c = make_cmd(OP_FILL, 0, py, COLUMNS_DEF, $urandom_range(100, ROWS_DEF - py),
                   $urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 1));
    end else if (r < 88) begin
      c = raw_cmd(OP_SEND);
    end else if (r < 92) begin
      c = raw_cmd(OP_MARK);
    end else if (r < 95) begin
      c = raw_cmd(OP_CLEAR);
    end else begin
      c = raw_cmd(OP_W'($urandom_range(5, 7)));
    end
    return c;
  endfunction

  task automatic issue(input command_t c, input int unsigned gap);
    start    <= 1'b1;
    op       <= c.op;
    x        <= c.x;
    y        <= c.y;
    width    <= c.width;
    height   <= c.height;
    value    <= c.value;
    rop      <= c.rop;
    fill_set <= c.fill_set;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  command_t directed [$];

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(make_cmd(OP_BLIT, 0, 0, 24, 0, 24'hFFFFFF, ROP_ANDNOT, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 376, 0, 24, 0, 24'hA5A5A5, ROP_XOR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 100, 0, 1, 0, 0, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 200, 0, 13, 0, 0, ROP_ANDNOT, 1'b1));
    directed.push_back(make_cmd(OP_BLIT, 300, 239, 24, 0, 0, ROP_OR, 1'b1));
    directed.push_back(make_cmd(OP_BLIT, 377, 239, 23, 0, 24'h5A5A5A, ROP_XOR, 1'b1));
    directed.push_back(make_cmd(OP_BLIT, 10, 3, 0, 0, 24'hFFFFFF, ROP_XOR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 10, 3, 25, 0, 24'hFFFFFF, ROP_XOR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 400, 3, 1, 0, 24'hFFFFFF, ROP_XOR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 390, 3, 11, 0, 24'hFFFFFF, ROP_XOR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 10, 240, 8, 0, 24'hFFFFFF, ROP_XOR, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 10, 3, 8, 0, 24'hFFFFFF, ROP_BAD, 1'b0));
    directed.push_back(make_cmd(OP_BLIT, 511, 255, 511, 255, 24'hFFFFFF, ROP_BAD, 1'b1));
    directed.push_back(make_cmd(OP_SEND, 0, 0, 0, 0, 0, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_FILL, 0, 1, 400, 2, 0, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_FILL, 10, 2, 50, 1, 1, ROP_BAD, 1'b1));
    directed.push_back(make_cmd(OP_FILL, 5, 5, 0, 5, 1, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_FILL, 5, 5, 5, 0, 1, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_FILL, 399, 5, 2, 1, 1, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_FILL, 0, 239, 8, 2, 1, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_FILL, 400, 240, 0, 0, 1, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_SEND, 0, 0, 0, 0, 0, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_SEND, 0, 0, 0, 0, 0, ROP_OR, 1'b0));
    directed.push_back(make_cmd(3'd5, 1, 2, 3, 4, 5, ROP_OR, 1'b0));
    directed.push_back(make_cmd(3'd7, 511, 255, 511, 255, 24'hFFFFFF, ROP_BAD, 1'b1));
    directed.push_back(make_cmd(OP_MARK, 0, 0, 0, 0, 0, ROP_OR, 1'b0));
    directed.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, ROP_OR, 1'b0));
    foreach (directed[i]) issue(directed[i], gap_len());

    // drain every dirty row so that send runs out of rows
    wait_drained();
    repeat (ROWS_DEF + 5) issue(raw_cmd(OP_SEND), gap_len());

    for (int i = 0; i < 230; i++) begin
      if (i == 115) wait_drained();
      issue(rand_cmd(), (i >= 80 && i < 120) ? 0 : gap_len());
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
